### rtl/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a property holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

### rtl/i2c_seq_pkg.sv
// Types and constants of the I2C sub-address transfer sequencer.
// No dependencies; used by i2c_master_subaddr_sequencer.
`default_nettype none

package i2c_seq_pkg;

  // Width of the remaining byte counter
  localparam int unsigned CountWidth = 16;

  // Operation codes
  localparam logic [1:0] OpStartRead  = 2'd0;
  localparam logic [1:0] OpStartWrite = 2'd1;
  localparam logic [1:0] OpEvent      = 2'd2;

  // Sub-address forms
  localparam logic [1:0] SubTwoBytes = 2'd2;
  localparam logic [1:0] SubPaged    = 2'd3;

  // Sub-address phase
  localparam logic [1:0] PhaseNone  = 2'd0;
  localparam logic [1:0] PhaseRead  = 2'd1;
  localparam logic [1:0] PhaseWrite = 2'd2;

  // Transfer status
  localparam logic [1:0] XferBusy  = 2'd0;
  localparam logic [1:0] XferOk    = 2'd1;
  localparam logic [1:0] XferError = 2'd2;

  // Engine status codes, low three bits dropped
  localparam logic [7:0] StStart       = 8'h08;
  localparam logic [7:0] StRepStart    = 8'h10;
  localparam logic [7:0] StAddrWrAck   = 8'h18;
  localparam logic [7:0] StAddrWrNack  = 8'h20;
  localparam logic [7:0] StDataWrAck   = 8'h28;
  localparam logic [7:0] StDataWrNack  = 8'h30;
  localparam logic [7:0] StArbLost     = 8'h38;
  localparam logic [7:0] StAddrRdAck   = 8'h40;
  localparam logic [7:0] StAddrRdNack  = 8'h48;
  localparam logic [7:0] StDataRdAck   = 8'h50;
  localparam logic [7:0] StDataRdNack  = 8'h58;
  localparam logic [7:0] StatusMask    = 8'hF8;

  // Control register bits
  localparam logic [6:0] CtrlAck    = 7'h04;
  localparam logic [6:0] CtrlIrq    = 7'h08;
  localparam logic [6:0] CtrlStop   = 7'h10;
  localparam logic [6:0] CtrlStart  = 7'h20;
  localparam logic [6:0] CtrlEnable = 7'h40;

  localparam logic [7:0] AddrRdMask = 8'hFE;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  device_address;
    logic [1:0]  subaddr_type;
    logic [15:0] subaddr;
    logic [15:0] byte_count;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] send_byte;
    logic       send_valid;
    logic       data_consumed;
    logic [6:0] control_set;
    logic [6:0] control_clear;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic [1:0] transfer_status;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/i2c_master_subaddr_sequencer.sv
// Status-driven I2C master sequencer for sub-address reads and writes.
// Depends on i2c_seq_pkg and assert_macros.svh.
//
// One item per clock cycle while the skid entry is empty: each start
// command or engine status event is decoded in the cycle it is accepted
// and its result lands in an output register, with one skid entry behind
// it so an item is still taken while a result waits. Transfer state (slave
// byte, sub-address, counters, phase, done flag) updates at acceptance, so
// the next item sees it at once.
`default_nettype none

module i2c_master_subaddr_sequencer (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire i2c_seq_pkg::in_item_t  in_item_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output i2c_seq_pkg::out_item_t      out_item_o
);
  import i2c_seq_pkg::*;

  // Transfer state
  logic [7:0]            slave_byte_q, slave_byte_d;
  logic [15:0]           subaddr_reg_q, subaddr_reg_d;
  logic [1:0]            subaddr_left_q, subaddr_left_d;
  logic [CountWidth-1:0] bytes_left_q, bytes_left_d;
  logic [1:0]            subaddr_phase_q, subaddr_phase_d;
  logic [1:0]            done_flag_q, done_flag_d;

  // Output register and skid entry
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_item_q, out_item_d;
  out_item_t skid_item_q, skid_item_d;

  logic                  in_fire;
  out_item_t             res;
  logic [CountWidth-1:0] cnt;
  logic [CountWidth-1:0] rx_left;
  logic [7:0]            stat;
  logic [7:0]            rd_bit;
  logic [7:0]            page_bits;
  logic                  fail;

  assign in_fire = in_valid_i && !in_stall_o;
  assign cnt     = CountWidth'(in_item_i.byte_count);
  assign stat    = in_item_i.status_code & StatusMask;
  assign rd_bit  = (in_item_i.operation == OpStartRead) ? 8'd1 : 8'd0;
  assign page_bits = {4'd0, in_item_i.subaddr[10:8], 1'b0};
  assign rx_left = (bytes_left_q != '0) ? (bytes_left_q - CountWidth'(1)) : bytes_left_q;

  // Decode one item against the current transfer state
  always_comb begin
    res             = '0;
    fail            = 1'b0;
    slave_byte_d    = slave_byte_q;
    subaddr_reg_d   = subaddr_reg_q;
    subaddr_left_d  = subaddr_left_q;
    bytes_left_d    = bytes_left_q;
    subaddr_phase_d = subaddr_phase_q;
    done_flag_d     = done_flag_q;

    if (in_item_i.operation == OpStartRead || in_item_i.operation == OpStartWrite) begin
      if (cnt == '0) begin
        fail = 1'b1;
      end else begin
        if (in_item_i.subaddr_type == SubPaged) begin
          slave_byte_d   = in_item_i.device_address + page_bits + rd_bit;
          subaddr_reg_d  = {8'd0, in_item_i.subaddr[7:0]};
          subaddr_left_d = 2'd1;
        end else begin
          slave_byte_d   = in_item_i.device_address + rd_bit;
          subaddr_reg_d  = in_item_i.subaddr;
          subaddr_left_d = (in_item_i.subaddr_type == SubTwoBytes) ? 2'd2 : 2'd1;
        end
        bytes_left_d      = cnt;
        subaddr_phase_d   = (in_item_i.operation == OpStartRead) ? PhaseRead : PhaseWrite;
        done_flag_d       = XferBusy;
        res.control_clear = CtrlStart | CtrlIrq | CtrlAck;
        res.control_set   = CtrlEnable | CtrlStart;
      end
    end else if (in_item_i.operation == OpEvent) begin
      unique case (stat) inside
        StStart: begin
          res.send_byte     = (subaddr_phase_q == PhaseRead) ? (slave_byte_q & AddrRdMask)
                                                             : slave_byte_q;
          res.send_valid    = 1'b1;
          res.control_clear = CtrlStart | CtrlIrq;
        end
        StRepStart: begin
          res.send_byte     = slave_byte_q;
          res.send_valid    = 1'b1;
          res.control_clear = CtrlStart | CtrlIrq;
        end
        StAddrWrAck, StDataWrAck: begin
          if (subaddr_phase_q == PhaseNone) begin
            // Data phase: send the next buffered byte or stop
            if (bytes_left_q != '0) begin
              res.send_byte     = in_item_i.tx_byte;
              res.send_valid    = 1'b1;
              res.data_consumed = 1'b1;
              res.control_clear = CtrlStart | CtrlIrq;
              bytes_left_d      = bytes_left_q - CountWidth'(1);
            end else begin
              res.control_set   = CtrlStop;
              res.control_clear = CtrlStart | CtrlIrq;
              done_flag_d       = XferOk;
            end
          end else if (subaddr_phase_q == PhaseRead || subaddr_phase_q == PhaseWrite) begin
            // Sub-address bytes, high byte first
            if (subaddr_left_q == 2'd2) begin
              res.send_byte     = subaddr_reg_q[15:8];
              res.send_valid    = 1'b1;
              res.control_clear = CtrlStart | CtrlIrq;
              subaddr_left_d    = 2'd1;
            end else if (subaddr_left_q == 2'd1) begin
              res.send_byte     = subaddr_reg_q[7:0];
              res.send_valid    = 1'b1;
              res.control_clear = CtrlStart | CtrlIrq;
              subaddr_left_d    = 2'd0;
              if (subaddr_phase_q == PhaseWrite) begin
                subaddr_phase_d = PhaseNone;
              end
            end else if (subaddr_left_q == 2'd0 && subaddr_phase_q == PhaseRead) begin
              // Sub-address done: issue the repeated start for the read
              res.control_clear = CtrlIrq;
              res.control_set   = CtrlStart;
              subaddr_phase_d   = PhaseNone;
            end
          end
        end
        StAddrRdAck: begin
          if (bytes_left_q <= CountWidth'(1)) begin
            res.control_clear = CtrlStart | CtrlIrq | CtrlAck;
          end else begin
            res.control_set   = CtrlAck;
            res.control_clear = CtrlStart | CtrlIrq;
          end
        end
        StAddrWrNack, StDataWrNack, StArbLost, StAddrRdNack: begin
          res.control_clear = CtrlStart | CtrlIrq;
          done_flag_d       = XferError;
        end
        StDataRdAck: begin
          // Store the byte; NACK the next one if it is the last
          res.rx_data  = in_item_i.rx_byte;
          res.rx_valid = 1'b1;
          bytes_left_d = rx_left;
          if (rx_left == CountWidth'(1)) begin
            res.control_clear = CtrlStart | CtrlIrq | CtrlAck;
          end else begin
            res.control_set   = CtrlAck;
            res.control_clear = CtrlStart | CtrlIrq;
          end
        end
        StDataRdNack: begin
          res.rx_data       = in_item_i.rx_byte;
          res.rx_valid      = 1'b1;
          res.control_set   = CtrlStop;
          res.control_clear = CtrlStart | CtrlIrq;
          done_flag_d       = XferOk;
        end
        default: begin
        end
      endcase
    end

    res.transfer_status = fail ? XferError : done_flag_d;
  end

  // Advance the output register and skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    skid_valid_d = skid_valid_q;
    skid_item_d  = skid_item_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_item_d   = skid_item_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_fire;
        out_item_d  = res;
      end
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_item_d  = res;
    end
  end

  // Control and transfer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q     <= 1'b0;
      skid_valid_q    <= 1'b0;
      slave_byte_q    <= '0;
      subaddr_reg_q   <= '0;
      subaddr_left_q  <= '0;
      bytes_left_q    <= '0;
      subaddr_phase_q <= PhaseNone;
      done_flag_q     <= XferBusy;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      if (in_fire) begin
        slave_byte_q    <= slave_byte_d;
        subaddr_reg_q   <= subaddr_reg_d;
        subaddr_left_q  <= subaddr_left_d;
        bytes_left_q    <= bytes_left_d;
        subaddr_phase_q <= subaddr_phase_d;
        done_flag_q     <= done_flag_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_item_q  <= out_item_d;
    skid_item_q <= skid_item_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid entry without output item")
  `ASSERT_CLK(a_subaddr_left_range, subaddr_left_q != 2'd3, "sub-address count out of range")
  `ASSERT_CLK(a_rx_send_excl, !out_valid_o || !(out_item_o.rx_valid && out_item_o.send_valid), "received and sent byte in one item")
  `ASSERT_NEXT(a_event_no_count_up, in_fire && in_item_i.operation == OpEvent, bytes_left_q <= $past(bytes_left_q), "byte count grew on a status event")

endmodule

`default_nettype wire

### sim/i2c_master_subaddr_sequencer_tb.sv
// Self-checking testbench for the I2C sub-address transfer sequencer.
// Depends on i2c_seq_pkg and i2c_master_subaddr_sequencer; drives start
// commands and bus status events, predicts every result and compares it.
`default_nettype none

module i2c_master_subaddr_sequencer_tb;
  import i2c_seq_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;
  localparam int BulkItems   = 1350;
  localparam int TotalItems  = 1550;
  localparam int HoldAt      = 400;
  localparam int HoldCycles  = 150;
  localparam int InBits      = $bits(in_item_t);

  // Codes the package does not name
  localparam logic [1:0] OpNone     = 2'd3;
  localparam logic [1:0] SubUnset   = 2'd0;
  localparam logic [1:0] SubOneByte = 2'd1;
  localparam logic [7:0] StBusError = 8'h00;
  localparam logic [7:0] StNoInfo   = 8'hF8;

  // Control bit groups used by the sequencer
  localparam logic [6:0] ClrStartIrq    = CtrlStart | CtrlIrq;
  localparam logic [6:0] ClrStartIrqAck = CtrlStart | CtrlIrq | CtrlAck;
  localparam logic [6:0] SetEnableStart = CtrlEnable | CtrlStart;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Transfer state as the sequencer should hold it
  logic [7:0]            slave_q = '0;
  logic [15:0]           subaddr_q = '0;
  logic [1:0]            sub_left_q = '0;
  logic [CountWidth-1:0] bytes_left_q = '0;
  logic [1:0]            phase_q = PhaseNone;
  logic [1:0]            done_q = XferBusy;

  in_item_t  pending_items[$];
  out_item_t bus_actions_due[$];

  int  items_accepted = 0;
  int  results_checked = 0;
  int  fail_count = 0;
  int  counted_items = 0;
  int  starts_sent = 0;
  int  events_sent = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  quiet = 1'b0;
  wire idle_ok = !quiet && ((items_accepted % 192) < 128);

  i2c_master_subaddr_sequencer i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #5 clk = ~clk;

  // Compute the bus action for one item and advance the transfer state
  function automatic out_item_t next_bus_action(in_item_t it);
    out_item_t  r;
    logic [7:0] st;
    logic [7:0] rd;
    bit         failed;
    r = '0;
    failed = 1'b0;
    st = it.status_code & StatusMask;
    if (it.operation == OpStartRead || it.operation == OpStartWrite) begin
      if (CountWidth'(it.byte_count) == '0) begin
        failed = 1'b1;
      end else begin
        rd = (it.operation == OpStartRead) ? 8'd1 : 8'd0;
        if (it.subaddr_type == SubPaged) begin
          slave_q = it.device_address + {4'b0, it.subaddr[10:8], 1'b0} + rd;
          subaddr_q = {8'h00, it.subaddr[7:0]};
          sub_left_q = 2'd1;
        end else begin
          slave_q = it.device_address + rd;
          subaddr_q = it.subaddr;
          sub_left_q = (it.subaddr_type == SubTwoBytes) ? 2'd2 : 2'd1;
        end
        bytes_left_q = CountWidth'(it.byte_count);
        phase_q = (it.operation == OpStartRead) ? PhaseRead : PhaseWrite;
        done_q = XferBusy;
        r.control_clear = ClrStartIrqAck;
        r.control_set = SetEnableStart;
      end
    end else if (it.operation == OpEvent) begin
      case (st)
        StStart: begin
          r.send_byte = (phase_q == PhaseRead) ? (slave_q & AddrRdMask) : slave_q;
          r.send_valid = 1'b1;
          r.control_clear = ClrStartIrq;
        end
        StRepStart: begin
          r.send_byte = slave_q;
          r.send_valid = 1'b1;
          r.control_clear = ClrStartIrq;
        end
        StAddrWrAck, StDataWrAck: begin
          if (phase_q == PhaseNone) begin
            if (bytes_left_q != '0) begin
              r.send_byte = it.tx_byte;
              r.send_valid = 1'b1;
              r.data_consumed = 1'b1;
              r.control_clear = ClrStartIrq;
              bytes_left_q = bytes_left_q - 1'b1;
            end else begin
              r.control_set = CtrlStop;
              r.control_clear = ClrStartIrq;
              done_q = XferOk;
            end
          end else if (phase_q == PhaseRead || phase_q == PhaseWrite) begin
            if (sub_left_q == 2'd2) begin
              r.send_byte = subaddr_q[15:8];
              r.send_valid = 1'b1;
              r.control_clear = ClrStartIrq;
              sub_left_q = 2'd1;
            end else if (sub_left_q == 2'd1) begin
              r.send_byte = subaddr_q[7:0];
              r.send_valid = 1'b1;
              r.control_clear = ClrStartIrq;
              sub_left_q = 2'd0;
              if (phase_q == PhaseWrite) phase_q = PhaseNone;
            end else if (sub_left_q == 2'd0 && phase_q == PhaseRead) begin
              // switch direction with a repeated start
              r.control_clear = CtrlIrq;
              r.control_set = CtrlStart;
              phase_q = PhaseNone;
            end
          end
        end
        StAddrRdAck: begin
          if (bytes_left_q <= 1) begin
            r.control_clear = ClrStartIrqAck;
          end else begin
            r.control_set = CtrlAck;
            r.control_clear = ClrStartIrq;
          end
        end
        StAddrWrNack, StDataWrNack, StArbLost, StAddrRdNack: begin
          r.control_clear = ClrStartIrq;
          done_q = XferError;
        end
        StDataRdAck: begin
          r.rx_data = it.rx_byte;
          r.rx_valid = 1'b1;
          if (bytes_left_q != '0) bytes_left_q = bytes_left_q - 1'b1;
          if (bytes_left_q == 1) begin
            r.control_clear = ClrStartIrqAck;
          end else begin
            r.control_set = CtrlAck;
            r.control_clear = ClrStartIrq;
          end
        end
        StDataRdNack: begin
          r.rx_data = it.rx_byte;
          r.rx_valid = 1'b1;
          r.control_set = CtrlStop;
          r.control_clear = ClrStartIrq;
          done_q = XferOk;
        end
        default: begin
        end
      endcase
    end
    r.transfer_status = failed ? XferError : done_q;
    return r;
  endfunction

  // Queue one item; only items the block reacts to count toward the total
  task automatic push_item(in_item_t it);
    pending_items.push_back(it);
    if (it.operation == OpStartRead || it.operation == OpStartWrite) begin
      starts_sent++;
      counted_items++;
    end else if (it.operation == OpEvent) begin
      events_sent++;
      case (it.status_code & StatusMask)
        StStart, StRepStart, StAddrWrAck, StAddrWrNack, StDataWrAck, StDataWrNack,
        StArbLost, StAddrRdAck, StAddrRdNack, StDataRdAck, StDataRdNack:
          counted_items++;
        default: begin
        end
      endcase
    end
  endtask

  task automatic push_start(logic [1:0] op, logic [7:0] dev, logic [1:0] form,
                            logic [15:0] sub, logic [15:0] cnt);
    in_item_t it;
    it = InBits'({$urandom, $urandom, $urandom});
    it.operation = op;
    it.device_address = dev;
    it.subaddr_type = form;
    it.subaddr = sub;
    it.byte_count = cnt;
    push_item(it);
  endtask

  // Status event with random low status bits and random data bytes
  task automatic push_event(logic [7:0] st);
    in_item_t it;
    it = InBits'({$urandom, $urandom, $urandom});
    it.operation = OpEvent;
    it.status_code = {st[7:3], 3'($urandom_range(0, 7))};
    push_item(it);
  endtask

  // One transfer with random content; counts above 8 are cut short, and some are cut by an error
  task automatic queue_transfer();
    logic [7:0]  steps[$];
    logic [7:0]  bad[4];
    logic [15:0] cnt;
    logic [7:0]  dev;
    logic [1:0]  form;
    bit          rd;
    int          moved;
    int          cut_at;
    bad = '{StAddrWrNack, StDataWrNack, StArbLost, StAddrRdNack};
    rd = 1'($urandom_range(0, 1));
    form = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 19))
      0: cnt = 16'd0;
      1: cnt = 16'($urandom);
      default: cnt = 16'($urandom_range(1, 6));
    endcase
    dev = ($urandom_range(0, 7) == 0) ? 8'($urandom) : {7'($urandom), 1'b0};
    push_start(rd ? OpStartRead : OpStartWrite, dev, form, 16'($urandom), cnt);
    if (cnt != 0) begin
      moved = (cnt > 8) ? 8 : int'(cnt);
      steps.push_back(StStart);
      steps.push_back(StAddrWrAck);
      if (form == SubTwoBytes) steps.push_back(StDataWrAck);
      if (rd) begin
        steps.push_back(StDataWrAck);
        steps.push_back(StRepStart);
        steps.push_back(StAddrRdAck);
        repeat (moved - 1) steps.push_back(StDataRdAck);
        if (cnt <= 8) steps.push_back(StDataRdNack);
      end else begin
        repeat (moved) steps.push_back(StDataWrAck);
        if (cnt <= 8) steps.push_back(StDataWrAck);
      end
      cut_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, steps.size() - 1)) : -1;
      foreach (steps[i]) begin
        if (i == cut_at) begin
          push_event(bad[$urandom_range(0, 3)]);
          break;
        end
        push_event(steps[i]);
      end
    end
  endtask

  // Mostly transfers, some loose items of any kind
  task automatic queue_random_until(int goal);
    in_item_t it;
    while (counted_items < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        it = InBits'({$urandom, $urandom, $urandom});
        if ($urandom_range(0, 1)) it.byte_count = 16'($urandom_range(0, 4));
        push_item(it);
      end else begin
        queue_transfer();
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || bus_actions_due.size() != 0)
      @(negedge clk);
  endtask

  // Driver: offer queued items, hold a stalled item, idle in bursts
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        bus_actions_due.push_back(next_bus_action(in_item));
        items_accepted <= items_accepted + 1;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_item <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off, otherwise random stall bursts
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && items_accepted >= HoldAt) begin
      hold_left <= HoldCycles - 1;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_ok && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: check each result against the oldest expected bus action
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bus_actions_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %h arrived with nothing expected", out_item);
      end else begin
        results_checked++;
        if (out_item.send_byte !== bus_actions_due[0].send_byte ||
            out_item.send_valid !== bus_actions_due[0].send_valid ||
            out_item.data_consumed !== bus_actions_due[0].data_consumed ||
            out_item.control_set !== bus_actions_due[0].control_set ||
            out_item.control_clear !== bus_actions_due[0].control_clear ||
            out_item.rx_data !== bus_actions_due[0].rx_data ||
            out_item.rx_valid !== bus_actions_due[0].rx_valid ||
            out_item.transfer_status !== bus_actions_due[0].transfer_status) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d: exp send %h/%b took %b set %h clr %h rx %h/%b st %0d",
                     results_checked,
                     bus_actions_due[0].send_byte, bus_actions_due[0].send_valid,
                     bus_actions_due[0].data_consumed, bus_actions_due[0].control_set,
                     bus_actions_due[0].control_clear, bus_actions_due[0].rx_data,
                     bus_actions_due[0].rx_valid, bus_actions_due[0].transfer_status);
            $display("result %0d: got send %h/%b took %b set %h clr %h rx %h/%b st %0d",
                     results_checked,
                     out_item.send_byte, out_item.send_valid, out_item.data_consumed,
                     out_item.control_set, out_item.control_clear, out_item.rx_data,
                     out_item.rx_valid, out_item.transfer_status);
          end
        end
        void'(bus_actions_due.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, bus_actions_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Reset, stimulus phases and final verdict
  initial begin
    in_item_t odd;
    // directed: idle state, saturation, zero count, ignored and unknown items
    push_event(StStart);
    push_event(StDataRdAck);
    push_start(OpStartWrite, 8'hA0, SubTwoBytes, 16'h1234, 16'd0);
    odd = '1;
    odd.operation = OpNone;
    push_item(odd);
    push_event(8'hFF);
    push_event(StBusError);
    // paged read whose address byte wraps, full count, ended by a NACK
    push_start(OpStartRead, 8'hFE, SubPaged, 16'hFFFF, 16'hFFFF);
    push_event(StStart);
    push_event(StAddrWrAck);
    push_event(StDataWrAck);
    push_event(StRepStart);
    push_event(StAddrRdAck);
    push_event(StDataRdAck);
    push_event(StAddrRdNack);
    // one-byte write with an unset form, then an event after completion
    push_start(OpStartWrite, 8'h00, SubUnset, 16'h00FF, 16'd1);
    push_event(StStart);
    push_event(StAddrWrAck);
    push_event(StDataWrAck);
    push_event(StDataWrAck);
    push_event(StNoInfo);
    push_event(StDataWrAck);
    // two-byte read of a single byte, ended by a NACK on the data byte
    push_start(OpStartRead, 8'h01, SubTwoBytes, 16'hABCD, 16'd1);
    push_event(StStart);
    push_event(StAddrWrAck);
    push_event(StDataWrAck);
    push_event(StDataWrAck);
    push_event(StRepStart);
    push_event(StAddrRdAck);
    push_event(StDataRdNack);
    push_start(OpStartWrite, 8'h42, SubOneByte, 16'h0000, 16'd2);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait_drained();
    queue_random_until(BulkItems);
    wait_drained();
    quiet = 1'b1;
    queue_random_until(TotalItems);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    if (bus_actions_due.size() != 0) begin
      fail_count += bus_actions_due.size();
      $display("%0d expected results never arrived", bus_actions_due.size());
    end
    $display("covered %0d items: %0d start commands, %0d bus events; %0d results checked",
             items_accepted, starts_sent, events_sent, results_checked);
    $display("%0d failures over %0d cycles", fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
